>>> src/sorted_key_set_table_unit_defines.svh
// Assertion macros used by the sorted key set table RTL.
`ifndef SORTED_KEY_SET_TABLE_UNIT_DEFINES_SVH
`define SORTED_KEY_SET_TABLE_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
// Property checked on the rising clock edge, ignored while reset is held.
`define SKSU_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Property checked on the rising clock edge at all times, reset included.
`define SKSU_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SKSU_ASSERT(lbl, clk, rst_n, prop, msg)
`define SKSU_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

>>> src/sksu_pkg.sv
// Package with the field widths, codes and types of the sorted key set table.
`default_nettype none

package sksu_pkg;

    // Field widths of the item channels.
    localparam int KEY_BITS    = 16;
    localparam int STATUS_BITS = 3;
    localparam int POS_BITS    = 5;
    localparam int COUNT_BITS  = 6;

    // Operation codes of an input item.
    localparam logic KIND_INSERT = 1'b0;
    localparam logic KIND_LOOKUP = 1'b1;

    // Status codes of a result item.
    localparam logic [STATUS_BITS-1:0] ST_INSERTED  = 3'd0;
    localparam logic [STATUS_BITS-1:0] ST_DUPLICATE = 3'd1;
    localparam logic [STATUS_BITS-1:0] ST_FOUND     = 3'd2;
    localparam logic [STATUS_BITS-1:0] ST_NOT_FOUND = 3'd3;
    localparam logic [STATUS_BITS-1:0] ST_FULL      = 3'd4;

    // Compare flags that one cell reports to the table controller.
    typedef struct packed {
        logic lt;     // Cell holds a key below the search key.
        logic eq;     // Cell holds the search key.
        logic first;  // First cell whose key is not below the search key.
    } t_cell_flags;

endpackage

`default_nettype wire

>>> src/sksu_channels.sv
// Request and response channel interfaces of the sorted key set table.
`default_nettype none

interface sksu_req_if import sksu_pkg::*; ();
    logic                valid;
    logic                ready;
    logic                kind;
    logic [KEY_BITS-1:0] key;

    modport source (output valid, output kind, output key, input ready);
    modport sink (input valid, input kind, input key, output ready);
endinterface

interface sksu_rsp_if import sksu_pkg::*; ();
    logic                   valid;
    logic                   ready;
    logic [STATUS_BITS-1:0] status;
    logic [POS_BITS-1:0]    position;
    logic [COUNT_BITS-1:0]  entry_count;

    modport source (output valid, output status, output position, output entry_count,
                    input ready);
    modport sink (input valid, input status, input position, input entry_count,
                  output ready);
endinterface

`default_nettype wire

>>> src/sksu_cell.sv
// One cell of the sorted key chain: holds a key, compares it and shifts on insert.
`default_nettype none

module sksu_cell import sksu_pkg::*; #(
    parameter int KEY_WIDTH = 16
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_occupied,
    input  wire logic                 i_prev_lt,
    input  wire logic [KEY_WIDTH-1:0] i_prev_key,
    input  wire logic [KEY_WIDTH-1:0] i_search_key,
    input  wire logic                 i_insert,
    output t_cell_flags               o_flags,
    output logic      [KEY_WIDTH-1:0] o_key
);

    logic [KEY_WIDTH-1:0] r_key;
    logic [KEY_WIDTH-1:0] n_key;
    logic                 lt;

    // Compare the held key against the search key.
    assign lt            = i_occupied && (r_key < i_search_key);
    assign o_flags.lt    = lt;
    assign o_flags.eq    = i_occupied && (r_key == i_search_key);
    assign o_flags.first = i_prev_lt && !lt;
    assign o_key         = r_key;

    // On insert, smaller keys stay, the boundary cell takes the new key and
    // every cell above it takes its lower neighbor's key.
    always_comb begin
        priority if (lt) begin
            n_key = r_key;
        end else if (i_prev_lt) begin
            n_key = i_search_key;
        end else begin
            n_key = i_prev_key;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_insert) begin
            r_key <= n_key;
        end
    end

endmodule

`default_nettype wire

>>> src/sorted_key_set_table_unit.sv
// Top level of the sorted key set table: a chain of key cells and its controller.
//
// The block keeps up to CAPACITY distinct keys in ascending order.
// Request channel i_req carries kind (0 insert, 1 look up) and key; the low
// KEY_WIDTH bits of key are used. Response channel o_rsp returns one item per
// request: status, position (sorted rank, or 0) and entry_count (keys held
// after the operation). Both channels use valid and ready; an item moves on
// a rising edge where both are high.
// Every cell compares its key with the request key in parallel, and an insert
// shifts all larger keys up by one cell in the same cycle, so the response to an
// accepted request is valid in the next cycle.
// Throughput is one item per cycle while the receiver does not stall, set by the
// single compare-and-shift pass through the cell chain.
// The response sits in an output register; a new request is taken whenever
// that register is empty or being emptied in the same cycle. While the
// receiver stalls, one response waits and further requests wait with it.
// Synchronous reset empties the table and the output register; key cells
// are not cleared, since cells at or above the entry count are never used.
`default_nettype none
`include "sorted_key_set_table_unit_defines.svh"

module sorted_key_set_table_unit import sksu_pkg::*; #(
    parameter int CAPACITY  = 32,
    parameter int KEY_WIDTH = 16
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    sksu_req_if.sink  i_req,
    sksu_rsp_if.source o_rsp
);

    localparam int RW   = $clog2(CAPACITY);
    localparam int CW   = $clog2(CAPACITY + 1);
    localparam int PEXT = (RW > POS_BITS) ? RW : POS_BITS;
    localparam int CEXT = (CW > COUNT_BITS) ? CW : COUNT_BITS;

    logic [KEY_WIDTH-1:0]   search_key;
    t_cell_flags            flags [CAPACITY];
    logic [KEY_WIDTH-1:0]   cell_key [CAPACITY];
    logic [CAPACITY-1:0]    eq_vec;
    logic [CAPACITY-1:0]    first_vec;
    logic [RW-1:0]          rank;
    logic                   hit;
    logic                   full;
    logic                   accept;
    logic                   insert;
    logic [CW-1:0]          r_count;
    logic [CW-1:0]          n_count;
    logic [STATUS_BITS-1:0] n_status;
    logic [RW-1:0]          n_pos;
    logic [PEXT-1:0]        pos_ext;
    logic [CEXT-1:0]        count_ext;
    logic                   r_out_valid;
    logic [STATUS_BITS-1:0] r_status;
    logic [POS_BITS-1:0]    r_pos;
    logic [COUNT_BITS-1:0]  r_entry_count;

    assign search_key = KEY_WIDTH'(i_req.key);

    // Chain of key cells; cell 0 sees an always-smaller lower neighbor.
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic                 prev_lt;
        logic [KEY_WIDTH-1:0] prev_key;
        if (g == 0) begin : g_head
            assign prev_lt  = 1'b1;
            assign prev_key = search_key;
        end else begin : g_link
            assign prev_lt  = flags[g-1].lt;
            assign prev_key = cell_key[g-1];
        end
        sksu_cell #(
            .KEY_WIDTH (KEY_WIDTH)
        ) u_cell (
            .i_clk        (i_clk),
            .i_occupied   (CW'(g) < r_count),
            .i_prev_lt    (prev_lt),
            .i_prev_key   (prev_key),
            .i_search_key (search_key),
            .i_insert     (insert),
            .o_flags      (flags[g]),
            .o_key        (cell_key[g])
        );
        assign eq_vec[g]    = flags[g].eq;
        assign first_vec[g] = flags[g].first;
    end

    // The boundary flag is at most one-hot, so the rank is an OR of cell indexes.
    always_comb begin
        rank = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            rank = rank | (first_vec[i] ? RW'(i) : RW'(0));
        end
    end

    assign hit    = |eq_vec;
    assign full   = (r_count == CW'(CAPACITY));
    assign accept = i_req.valid && i_req.ready;
    assign insert = accept && (i_req.kind == KIND_INSERT) && !hit && !full;

    // Decide the status of the accepted item.
    always_comb begin
        n_pos   = '0;
        n_count = r_count;
        priority if (i_req.kind == KIND_LOOKUP) begin
            n_status = hit ? ST_FOUND : ST_NOT_FOUND;
            n_pos    = hit ? rank : RW'(0);
        end else if (hit) begin
            n_status = ST_DUPLICATE;
        end else if (full) begin
            n_status = ST_FULL;
        end else begin
            n_status = ST_INSERTED;
            n_pos    = rank;
            n_count  = r_count + CW'(1);
        end
    end

    assign pos_ext   = PEXT'(n_pos);
    assign count_ext = CEXT'(n_count);

    // Entry count and output register valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (insert) begin
                r_count <= n_count;
            end
            if (accept) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Response payload register.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_status      <= n_status;
            r_pos         <= pos_ext[POS_BITS-1:0];
            r_entry_count <= count_ext[COUNT_BITS-1:0];
        end
    end

    assign i_req.ready       = !r_out_valid || o_rsp.ready;
    assign o_rsp.valid       = r_out_valid;
    assign o_rsp.status      = r_status;
    assign o_rsp.position    = r_pos;
    assign o_rsp.entry_count = r_entry_count;

    // The table never holds more keys than it has cells; the count is only
    // defined once reset has been seen.
    `SKSU_ASSERT_ALWAYS(a_count_bound, i_clk, !i_rst_n || (r_count <= CW'(CAPACITY)), "count above capacity")
    // Keys are distinct, so at most one cell matches.
    `SKSU_ASSERT(a_eq_onehot, i_clk, i_rst_n, $onehot0(eq_vec), "search key held in two cells")
    // Sorted order gives at most one insertion boundary.
    `SKSU_ASSERT(a_first_onehot, i_clk, i_rst_n, $onehot0(first_vec), "several insert boundaries")
    // An insert grows the table by exactly one key.
    `SKSU_ASSERT(a_insert_grows, i_clk, i_rst_n, insert |=> (r_count == $past(r_count) + CW'(1)), "insert did not add one key")

endmodule

`default_nettype wire

>>> tb/sv/sorted_key_set_table_unit_checker.sv
`timescale 1ns / 100ps
// Response checker for the sorted key set table: tracks the key set and compares each response.
module sorted_key_set_table_unit_checker import sksu_pkg::*; #(
    parameter int CAPACITY  = 32,
    parameter int KEY_WIDTH = 16
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    sksu_req_if       i_req,
    sksu_rsp_if       i_rsp,
    output int        o_mismatches,
    output int        o_pending
);

    // Only the low KEY_WIDTH bits of a request key take part.
    localparam logic [KEY_BITS-1:0] KEY_MASK = KEY_BITS'((64'd1 << KEY_WIDTH) - 64'd1);

    typedef struct packed {
        logic [STATUS_BITS-1:0] status;
        logic [POS_BITS-1:0]    position;
        logic [COUNT_BITS-1:0]  entry_count;
    } t_table_rsp;

    // Shadow copy of the table: ascending keys in cells 0 .. held_n-1.
    logic [KEY_BITS-1:0] held_keys [CAPACITY];
    int                  held_n = 0;
    t_table_rsp          awaited_rsp [$];
    int                  mismatch_count = 0;

    // Prints one line per mismatch and counts it.
    task automatic report_mismatch(input string msg);
        $display("%0t ns: %s", $time, msg);
        mismatch_count++;
    endtask

    // Applies one insert or lookup to the shadow table and returns its response.
    function automatic t_table_rsp apply_key_op(input logic kind, input logic [KEY_BITS-1:0] raw_key);
        logic [KEY_BITS-1:0] k;
        int                  rank;
        bit                  hit;
        t_table_rsp          r;
        k    = raw_key & KEY_MASK;
        rank = 0;
        hit  = 1'b0;
        for (int i = 0; i < held_n; i++) begin
            if (held_keys[i] < k) begin
                rank++;
            end else if (held_keys[i] == k) begin
                hit = 1'b1;
            end
        end
        r.position = '0;
        if (kind == KIND_LOOKUP) begin
            if (hit) begin
                r.status   = ST_FOUND;
                r.position = POS_BITS'(rank);
            end else begin
                r.status = ST_NOT_FOUND;
            end
        end else if (hit) begin
            // A held key is a duplicate even when the table is full.
            r.status = ST_DUPLICATE;
        end else if (held_n >= CAPACITY) begin
            r.status = ST_FULL;
        end else begin
            // Shift every larger key up one cell and drop the new key into the gap.
            for (int i = held_n; i > rank; i--) begin
                held_keys[i] = held_keys[i-1];
            end
            held_keys[rank] = k;
            held_n++;
            r.status   = ST_INSERTED;
            r.position = POS_BITS'(rank);
        end
        r.entry_count = COUNT_BITS'(held_n);
        return r;
    endfunction

    // Compare each accepted response with the oldest prediction, then predict new requests.
    always @(posedge i_clk) begin : track_items
        t_table_rsp want;
        if (!i_rst_n) begin
            held_n = 0;
            awaited_rsp.delete();
        end else begin
            if (i_rsp.valid === 1'b1 && i_rsp.ready === 1'b1) begin
                if (awaited_rsp.size() == 0) begin
                    report_mismatch($sformatf("response with no request waiting: status %0d",
                                              i_rsp.status));
                end else begin
                    want = awaited_rsp.pop_front();
                    if (i_rsp.status !== want.status) begin
                        report_mismatch($sformatf("status %0d, expected %0d",
                                                  i_rsp.status, want.status));
                    end
                    if (i_rsp.position !== want.position) begin
                        report_mismatch($sformatf("position %0d, expected %0d",
                                                  i_rsp.position, want.position));
                    end
                    if (i_rsp.entry_count !== want.entry_count) begin
                        report_mismatch($sformatf("entry_count %0d, expected %0d",
                                                  i_rsp.entry_count, want.entry_count));
                    end
                end
            end
            if (i_req.valid === 1'b1 && i_req.ready === 1'b1) begin
                awaited_rsp.push_back(apply_key_op(i_req.kind, i_req.key));
            end
        end
        o_pending    <= awaited_rsp.size();
        o_mismatches <= mismatch_count;
    end

endmodule

>>> tb/sv/sorted_key_set_table_unit_tb.sv
`timescale 1ns / 100ps
// Testbench top for the sorted key set table: clock, reset, request stimulus and verdict.
module sorted_key_set_table_unit_tb;
    import sksu_pkg::*;

    localparam int TABLE_CAPACITY  = 32;
    localparam int TABLE_KEY_WIDTH = 16;

    logic                clk       = 1'b0;
    logic                rst_n     = 1'b0;
    logic                req_valid = 1'b0;
    logic                req_kind  = KIND_LOOKUP;
    logic [KEY_BITS-1:0] req_key   = '0;
    logic                rsp_ready = 1'b0;
    logic [10:0]         stall_cyc = '0;
    int                  burst_left = 0;
    int                  mismatches;
    int                  pending;
    // Every key ever sent for insert, used to aim lookups and duplicates at held keys.
    logic [KEY_BITS-1:0] sent_keys [$];

    sksu_req_if req_ch ();
    sksu_rsp_if rsp_ch ();

    assign req_ch.valid = req_valid;
    assign req_ch.kind  = req_kind;
    assign req_ch.key   = req_key;
    assign rsp_ch.ready = rsp_ready;

    sorted_key_set_table_unit #(
        .CAPACITY  (TABLE_CAPACITY),
        .KEY_WIDTH (TABLE_KEY_WIDTH)
    ) u_dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch)
    );

    sorted_key_set_table_unit_checker #(
        .CAPACITY  (TABLE_CAPACITY),
        .KEY_WIDTH (TABLE_KEY_WIDTH)
    ) u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_req        (req_ch),
        .i_rsp        (rsp_ch),
        .o_mismatches (mismatches),
        .o_pending    (pending)
    );

    // 20 ns clock.
    always begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Receiver stalls follow a mode taken from bits 10 to 8 of a free-running cycle counter.
    always @(posedge clk) begin
        stall_cyc <= stall_cyc + 11'd1;
        case (stall_cyc[10:8])
            3'd2, 3'd6: rsp_ready <= ($urandom_range(1, 0) == 0);
            3'd3:       rsp_ready <= (stall_cyc[1:0] != 2'd3);
            3'd4:       rsp_ready <= ($urandom_range(7, 0) == 0);
            3'd7:       rsp_ready <= ($urandom_range(3, 0) != 0);
            default:    rsp_ready <= 1'b1;
        endcase
    end

    // Offers one item, holds it until accepted, then maybe ends the burst with a gap.
    task automatic send_item(input logic kind, input logic [KEY_BITS-1:0] key);
        int gap;
        req_valid <= 1'b1;
        req_kind  <= kind;
        req_key   <= key;
        @(posedge clk);
        while (!req_ch.ready) @(posedge clk);
        if (kind == KIND_INSERT) begin
            sent_keys.push_back(key);
        end
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            gap = ($urandom_range(9, 0) == 0) ? $urandom_range(30, 10) : $urandom_range(6, 1);
            req_valid <= 1'b0;
            req_kind  <= KIND_BITS_NOISE();
            req_key   <= KEY_BITS'($urandom);
            repeat (gap) @(posedge clk);
            burst_left = ($urandom_range(9, 0) == 0) ? 200 : $urandom_range(24, 0);
        end
    endtask

    // Random kind for the idle payload.
    function automatic logic KIND_BITS_NOISE();
        return ($urandom_range(1, 0) == 0) ? KIND_INSERT : KIND_LOOKUP;
    endfunction

    // Stops offering items until every response has come back.
    task automatic wait_for_drain();
        req_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
    endtask

    // Mostly held keys and their neighbors, some fresh keys and the extremes.
    function automatic logic [KEY_BITS-1:0] pick_key();
        int                  sel;
        logic [KEY_BITS-1:0] k;
        sel = $urandom_range(99, 0);
        if (sent_keys.size() == 0 || sel < 40) begin
            k = KEY_BITS'($urandom);
        end else if (sel < 85) begin
            k = sent_keys[$urandom_range(sent_keys.size() - 1, 0)];
        end else if (sel < 95) begin
            k = sent_keys[$urandom_range(sent_keys.size() - 1, 0)];
            k = sel[0] ? k + 16'd1 : k - 16'd1;
        end else begin
            k = sel[0] ? '0 : '1;
        end
        return k;
    endfunction

    initial begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part: empty table, extremes, ordering, duplicates and misses.
        send_item(KIND_LOOKUP, 16'h0000);
        send_item(KIND_LOOKUP, 16'hFFFF);
        send_item(KIND_INSERT, 16'h8000);
        send_item(KIND_INSERT, 16'h0000);
        send_item(KIND_INSERT, 16'hFFFF);
        send_item(KIND_INSERT, 16'h0000);
        send_item(KIND_LOOKUP, 16'h0000);
        send_item(KIND_LOOKUP, 16'hFFFF);
        send_item(KIND_LOOKUP, 16'h7FFF);
        send_item(KIND_INSERT, 16'h7FFF);
        send_item(KIND_INSERT, 16'h8001);
        send_item(KIND_LOOKUP, 16'h8001);
        send_item(KIND_INSERT, 16'h5AA5);
        send_item(KIND_LOOKUP, 16'h5AA5);
        send_item(KIND_INSERT, 16'hA55A);
        send_item(KIND_LOOKUP, 16'h8000);

        // Table fills slowly, so many lookups see a partly filled table.
        for (int n = 0; n < 900; n++) begin
            send_item(($urandom_range(99, 0) < 8) ? KIND_INSERT : KIND_LOOKUP, pick_key());
        end

        // Let everything drain, then push the table to full and beyond.
        wait_for_drain();
        for (int n = 0; n < 40; n++) begin
            send_item(KIND_INSERT, KEY_BITS'($urandom));
        end
        send_item(KIND_INSERT, sent_keys[0]);
        send_item(KIND_INSERT, 16'h0001);

        // Full table: duplicates, rejected inserts, hits and misses.
        for (int n = 0; n < 900; n++) begin
            send_item(($urandom_range(99, 0) < 40) ? KIND_INSERT : KIND_LOOKUP, pick_key());
        end

        wait_for_drain();
        repeat (8) @(posedge clk);
        if (mismatches == 0) begin
            $display("sorted_key_set_table_unit_tb passed");
        end else begin
            $display("sorted_key_set_table_unit_tb failed");
        end
        $finish;
    end

    // Run limit, far above the slowest correct run.
    initial begin
        #5_000_000;
        $display("sorted_key_set_table_unit_tb failed");
        $finish;
    end

endmodule
